FILE: rtl/core/hcbp_pkg.sv
package hcbp_pkg;

    localparam int MAX_CODE_LEN  = 16;
    localparam int ALPHABET_SIZE = 256;

    localparam int SYM_W    = 8;
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int REQ_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int NBITS_W  = 4;
    localparam int ACC_W    = 7;
    localparam int PEND_W   = 3;
    localparam int COMB_W   = ACC_W + CODE_W;
    localparam int TOTAL_W  = $clog2(COMB_W + 1);
    localparam int LEN_CAP  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    localparam int TBL_DEPTH = ALPHABET_SIZE;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int ENTRY_W   = CODE_W + LEN_W;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [NBITS_W-1:0] valid_bits;
        logic               last;
    } t_out;

    typedef struct packed {
        logic              vld;
        logic [REQ_W-1:0]  req_type;
        logic              hit;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_lookup;

    typedef struct packed {
        logic [1:0] count;
        t_out       res0;
        t_out       res1;
    } t_emit;

endpackage

FILE: rtl/core/hcbp_ram.sv
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/hcbp_table.sv
module hcbp_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  hcbp_pkg::t_in    i_req,
    input  logic             i_fire,
    output logic             o_busy,
    output hcbp_pkg::t_lookup o_lookup
);

    logic [hcbp_pkg::TBL_AW-1:0]  addr;
    logic                         sym_ok;
    logic                         load_we;
    logic [hcbp_pkg::LEN_W-1:0]   len_sat;
    logic                         ram_we;
    logic [hcbp_pkg::TBL_AW-1:0]  ram_waddr;
    logic [hcbp_pkg::ENTRY_W-1:0] wdata;
    logic [hcbp_pkg::ENTRY_W-1:0] rdata;
    logic [hcbp_pkg::LEN_W-1:0]   rd_len;

    logic                         r_clearing;
    logic [hcbp_pkg::TBL_AW-1:0]  r_clr_addr;
    logic                         r_s1_vld;
    logic [hcbp_pkg::REQ_W-1:0]   r_s1_req;
    logic                         r_s1_sym_ok;

    assign addr    = i_req.symbol[hcbp_pkg::TBL_AW-1:0];
    assign sym_ok  = (9'(i_req.symbol) < 9'(hcbp_pkg::ALPHABET_SIZE));
    assign load_we = i_accept && (i_req.req_type == hcbp_pkg::REQ_LOAD) && sym_ok;
    assign len_sat = (i_req.code_len > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP))
                   ? hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP) : i_req.code_len;

    // clearing pass writes zero length into every entry after reset
    assign ram_we    = r_clearing || load_we;
    assign ram_waddr = r_clearing ? r_clr_addr : addr;
    assign wdata     = r_clearing ? '0 : {i_req.code_bits, len_sat};
    assign o_busy    = r_clearing;

    hcbp_ram #(
        .WIDTH (hcbp_pkg::ENTRY_W),
        .DEPTH (hcbp_pkg::TBL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wdata),
        .i_re    (i_accept),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + hcbp_pkg::TBL_AW'(1);
            if (r_clr_addr == hcbp_pkg::TBL_AW'(hcbp_pkg::TBL_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_accept) begin
            r_s1_vld <= 1'b1;
        end else if (i_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_req    <= i_req.req_type;
            r_s1_sym_ok <= sym_ok;
        end
    end

    assign rd_len = rdata[hcbp_pkg::LEN_W-1:0];

    always_comb begin
        o_lookup          = '0;
        o_lookup.vld      = r_s1_vld;
        o_lookup.req_type = r_s1_req;
        o_lookup.hit      = (r_s1_req == hcbp_pkg::REQ_ENCODE) && r_s1_sym_ok
                          && (rd_len != '0);
        o_lookup.code     = rdata[hcbp_pkg::ENTRY_W-1:hcbp_pkg::LEN_W];
        o_lookup.len      = rd_len;
    end

endmodule

FILE: rtl/core/hcbp_pack.sv
module hcbp_pack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcbp_pkg::t_lookup i_lookup,
    input  logic              i_fire,
    output hcbp_pkg::t_emit   o_emit
);

    logic [hcbp_pkg::ACC_W-1:0]   r_acc;
    logic [hcbp_pkg::PEND_W-1:0]  r_pend;
    logic [hcbp_pkg::ACC_W-1:0]   n_acc;
    logic [hcbp_pkg::PEND_W-1:0]  n_pend;

    logic [hcbp_pkg::LEN_W-1:0]   clen;
    logic [hcbp_pkg::CODE_W-1:0]  mask;
    logic [hcbp_pkg::CODE_W-1:0]  code_m;
    logic [hcbp_pkg::COMB_W-1:0]  comb;
    logic [hcbp_pkg::TOTAL_W-1:0] total;
    logic [hcbp_pkg::BYTE_W-1:0]  byte0;
    logic [hcbp_pkg::BYTE_W-1:0]  byte1;
    logic [hcbp_pkg::PEND_W-1:0]  rem;
    logic [hcbp_pkg::ACC_W-1:0]   rem_mask;

    assign clen     = i_lookup.hit ? i_lookup.len : '0;
    assign mask     = hcbp_pkg::CODE_W'(((hcbp_pkg::CODE_W+1)'(1) << clen)
                    - (hcbp_pkg::CODE_W+1)'(1));
    assign code_m   = i_lookup.code & mask;
    assign comb     = (hcbp_pkg::COMB_W'(r_acc) << clen) | hcbp_pkg::COMB_W'(code_m);
    assign total    = hcbp_pkg::TOTAL_W'(r_pend) + hcbp_pkg::TOTAL_W'(clen);
    assign byte0    = hcbp_pkg::BYTE_W'(comb >> (total - hcbp_pkg::TOTAL_W'(8)));
    assign byte1    = hcbp_pkg::BYTE_W'(comb >> (total - hcbp_pkg::TOTAL_W'(16)));
    assign rem      = total[hcbp_pkg::PEND_W-1:0];
    assign rem_mask = hcbp_pkg::ACC_W'((8'd1 << rem) - 8'd1);

    always_comb begin
        o_emit = '0;
        n_acc  = r_acc;
        n_pend = r_pend;
        unique case (i_lookup.req_type)
            hcbp_pkg::REQ_ENCODE: begin
                o_emit.res0 = '{out_byte: byte0, valid_bits: 4'd8, last: 1'b1};
                if (total >= hcbp_pkg::TOTAL_W'(16)) begin
                    o_emit.count     = 2'd2;
                    o_emit.res0.last = 1'b0;
                    o_emit.res1 = '{out_byte: byte1, valid_bits: 4'd8, last: 1'b1};
                end else if (total >= hcbp_pkg::TOTAL_W'(8)) begin
                    o_emit.count = 2'd1;
                end
                n_acc  = hcbp_pkg::ACC_W'(comb) & rem_mask;
                n_pend = rem;
            end
            hcbp_pkg::REQ_FLUSH: begin
                if (r_pend != '0) begin
                    o_emit.count = 2'd1;
                    o_emit.res0.out_byte = hcbp_pkg::BYTE_W'(
                        {1'b0, r_acc} << (4'd8 - {1'b0, r_pend}));
                    o_emit.res0.valid_bits = hcbp_pkg::NBITS_W'(r_pend);
                    o_emit.res0.last = 1'b1;
                end
                n_acc  = '0;
                n_pend = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= '0;
        end else if (i_fire) begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

endmodule

FILE: rtl/core/hcbp_outq.sv
module hcbp_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  hcbp_pkg::t_emit i_emit,
    output logic            o_room,
    output logic            o_valid,
    output hcbp_pkg::t_out  o_data,
    input  logic            i_stall
);

    hcbp_pkg::t_out                r_q [hcbp_pkg::OQ_DEPTH];
    logic [hcbp_pkg::OQ_AW-1:0]    r_wr;
    logic [hcbp_pkg::OQ_AW-1:0]    r_rd;
    logic [hcbp_pkg::OQ_CNT_W-1:0] r_cnt;

    logic [1:0]                    push;
    logic                          pop;
    logic [hcbp_pkg::OQ_AW-1:0]    wr1;

    assign push    = i_fire ? i_emit.count : 2'd0;
    assign pop     = o_valid && !i_stall;
    assign wr1     = r_wr + hcbp_pkg::OQ_AW'(1);
    assign o_room  = (r_cnt <= hcbp_pkg::OQ_CNT_W'(hcbp_pkg::OQ_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_q[r_wr] <= i_emit.res0;
        end
        if (push == 2'd2) begin
            r_q[wr1] <= i_emit.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + hcbp_pkg::OQ_AW'(push);
            r_rd  <= r_rd + hcbp_pkg::OQ_AW'(pop);
            r_cnt <= r_cnt + hcbp_pkg::OQ_CNT_W'(push) - hcbp_pkg::OQ_CNT_W'(pop);
        end
    end

endmodule

FILE: rtl/core/huffman_code_bit_packer.sv
// huffman code bit packer: back end of a streaming huffman encoder
// input channel (i_in_valid, o_in_stall, i_in_data): a transfer carries a
// load, encode or flush request. a load writes the code word and length of
// one symbol into the code table; an encode looks the symbol up and packs
// its code MSB first into bytes; a flush emits the partial byte, zero padded
// output channel (o_out_valid, i_out_stall, o_out_data): one byte per
// transfer with its count of meaningful bits; last marks the final byte
// that a request produces. loads, absent symbols and empty flushes produce
// no transfer
// an accepted request is read from the table ram into the lookup stage
// register; once the result queue has room its bytes are written into the
// queue, which offers them on the output channel
// throughput: one request per cycle while the output keeps up; an encode
// that completes two bytes hands them out one at a time through the
// single-byte output port behind a four-entry result queue
// reset: the queue and the bit accumulator empty; the table then clears its
// 256 lengths one entry per cycle with o_in_stall high while it clears;
// code words read as zero until loaded
// a stall on the output holds the current byte; once the queue cannot take
// two more bytes the lookup stage holds and o_in_stall rises
module huffman_code_bit_packer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hcbp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output hcbp_pkg::t_out o_out_data
);

    logic              accept;
    logic              fire;
    logic              room;
    logic              busy;
    hcbp_pkg::t_lookup lookup;
    hcbp_pkg::t_emit   emit;

    assign fire       = lookup.vld && room;
    assign o_in_stall = busy || (lookup.vld && !room);
    assign accept     = i_in_valid && !o_in_stall;

    hcbp_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_data),
        .i_fire   (fire),
        .o_busy   (busy),
        .o_lookup (lookup)
    );

    hcbp_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lookup (lookup),
        .i_fire   (fire),
        .o_emit   (emit)
    );

    hcbp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_emit  (emit),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

FILE: rtl/core/hcbp_checker.sv
module hcbp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input hcbp_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input hcbp_pkg::t_out o_out_data
);

    // a stalled byte stays offered and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transfer changed");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.valid_bits != 4'd0)
                     && (o_out_data.valid_bits <= 4'd8))
        else $error("valid bit count out of range");

    // a partial byte only comes from a flush, which ends its request
    a_partial_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.valid_bits != 4'd8) |-> o_out_data.last)
        else $error("partial byte not marked last");

    // table clearing holds the input off right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid && o_in_stall)
        else $error("output not empty after reset");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);
